FILE: src/ntp_pkg.sv
// ntp_pkg: shared widths, field types and codes for the timestamp pairer.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package ntp_pkg;

    localparam int TIME_W     = 27;
    localparam int HANDLE_W   = 16;
    localparam int S_DATA_W   = 72;
    localparam int S_USER_W   = 1;
    localparam int M_DATA_W   = 120;
    localparam int M_USER_W   = 2;

    // kind of an incoming item
    localparam logic FUNC_FRAME = 1'b0;
    localparam logic FUNC_POSE  = 1'b1;

    typedef logic [TIME_W-1:0]   time_t;
    typedef logic [HANDLE_W-1:0] handle_t;

    typedef struct packed {
        logic    func;
        time_t   stamp_ms;
        time_t   camera_ms;
        handle_t handle;
    } in_item_t;

    typedef struct packed {
        time_t   ms;
        time_t   camera_ms;
        handle_t handle;
    } frame_entry_t;

    typedef struct packed {
        time_t   ms;
        handle_t handle;
    } pose_entry_t;

    typedef struct packed {
        logic    paired;
        time_t   frame_ms;
        time_t   frame_camera_ms;
        handle_t frame_handle;
        time_t   pose_ms;
        handle_t pose_handle;
        logic    overflowed;
    } result_t;

endpackage

FILE: src/ntp_in_queue.sv
// ntp_in_queue: front end; takes input items off the stream port, unpacks
// and tags them, and holds up to two of them for the matcher. Uses ntp_pkg.
`timescale 1ns / 1ps

module ntp_in_queue
    import ntp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic [S_USER_W-1:0] s_tuser,
    output logic                q_valid,
    input  logic                q_ready,
    output in_item_t            q_item
);

    in_item_t   entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    in_item_t   item_in;
    logic       push, pop;

    always_comb begin
        item_in.func      = s_tuser[0];
        item_in.stamp_ms  = s_tdata[TIME_W-1:0];
        item_in.camera_ms = s_tdata[2*TIME_W-1:TIME_W];
        item_in.handle    = s_tdata[2*TIME_W+HANDLE_W-1:2*TIME_W];
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = entry_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

FILE: src/ntp_matcher.sv
// ntp_matcher: back end; appends items to the frame and pose ring buffers,
// walks them for the nearest pair, drops consumed entries and holds the
// result in an output register. Uses ntp_pkg.
`timescale 1ns / 1ps

module ntp_matcher
    import ntp_pkg::*;
#(
    parameter int FIFO_DEPTH = 16
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     q_valid,
    output logic     q_ready,
    input  in_item_t q_item,
    output logic     r_valid,
    input  logic     r_ready,
    output result_t  r_data
);

    localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(FIFO_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_APPEND = 3'd1;
    localparam logic [2:0] ST_START  = 3'd2;
    localparam logic [2:0] ST_RD     = 3'd3;
    localparam logic [2:0] ST_CMP    = 3'd4;
    localparam logic [2:0] ST_PAIR   = 3'd5;
    localparam logic [2:0] ST_EMIT   = 3'd6;

    // ring index of entry off past head
    function automatic logic [AW-1:0] wrap_idx(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW+1)'(base) + (CW+1)'(off);
        if (s >= (CW+1)'(FIFO_DEPTH)) begin
            s = s - (CW+1)'(FIFO_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    frame_entry_t f_mem [FIFO_DEPTH];
    pose_entry_t  p_mem [FIFO_DEPTH];
    frame_entry_t f_rd_reg;
    pose_entry_t  p_rd_reg;

    logic [2:0]    state_reg, state_next;
    in_item_t      item_reg, item_next;
    logic          ovf_reg, ovf_next;
    logic [AW-1:0] f_head_reg, f_head_next, p_head_reg, p_head_next;
    logic [CW-1:0] f_cnt_reg, f_cnt_next, p_cnt_reg, p_cnt_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next;
    logic          have_reg, have_next;
    time_t         dmag_reg, dmag_next;
    logic          dpos_reg, dpos_next;
    logic          fetch_reg, fetch_next;
    logic [CW-1:0] drop_f_reg, drop_f_next, drop_p_reg, drop_p_next;
    result_t       res_reg, res_next;
    result_t       out_reg, out_next;
    logic          out_valid_reg, out_valid_next;

    logic          p_gt, eq, keep;
    time_t         mag_d;
    logic [CW-1:0] i_inc, j_inc;
    logic [AW-1:0] f_wr_addr, p_wr_addr, f_rd_addr, p_rd_addr;

    assign q_ready = (state_reg == ST_IDLE);
    assign r_valid = out_valid_reg;
    assign r_data  = out_reg;

    assign f_wr_addr = wrap_idx(f_head_reg, f_cnt_reg);
    assign p_wr_addr = wrap_idx(p_head_reg, p_cnt_reg);
    assign f_rd_addr = wrap_idx(f_head_reg, i_reg);
    assign p_rd_addr = wrap_idx(p_head_reg, j_reg);

    assign p_gt  = p_rd_reg.ms > f_rd_reg.ms;
    assign eq    = p_rd_reg.ms == f_rd_reg.ms;
    assign mag_d = p_gt ? (p_rd_reg.ms - f_rd_reg.ms) : (f_rd_reg.ms - p_rd_reg.ms);
    assign keep  = !have_reg || (mag_d < dmag_reg);
    assign i_inc = i_reg + ONE_C;
    assign j_inc = j_reg + ONE_C;

    always_comb begin
        state_next     = state_reg;
        item_next      = item_reg;
        ovf_next       = ovf_reg;
        f_head_next    = f_head_reg;
        p_head_next    = p_head_reg;
        f_cnt_next     = f_cnt_reg;
        p_cnt_next     = p_cnt_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        have_next      = have_reg;
        dmag_next      = dmag_reg;
        dpos_next      = dpos_reg;
        fetch_next     = fetch_reg;
        drop_f_next    = drop_f_reg;
        drop_p_next    = drop_p_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !r_ready;

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    item_next  = q_item;
                    ovf_next   = 1'b0;
                    state_next = ST_APPEND;
                end
            end
            ST_APPEND: begin
                // full ring: the new entry overwrites the oldest one
                if (item_reg.func == FUNC_FRAME) begin
                    if (f_cnt_reg == DEPTH_C) begin
                        f_head_next = wrap_idx(f_head_reg, ONE_C);
                        ovf_next    = 1'b1;
                    end else begin
                        f_cnt_next = f_cnt_reg + ONE_C;
                    end
                end else begin
                    if (p_cnt_reg == DEPTH_C) begin
                        p_head_next = wrap_idx(p_head_reg, ONE_C);
                        ovf_next    = 1'b1;
                    end else begin
                        p_cnt_next = p_cnt_reg + ONE_C;
                    end
                end
                state_next = ST_START;
            end
            ST_START: begin
                i_next     = '0;
                j_next     = '0;
                have_next  = 1'b0;
                fetch_next = 1'b0;
                if (f_cnt_reg == '0 || p_cnt_reg == '0) begin
                    res_next            = '0;
                    res_next.overflowed = ovf_reg;
                    drop_f_next         = '0;
                    drop_p_next         = '0;
                    state_next          = ST_EMIT;
                end else begin
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                state_next = fetch_reg ? ST_PAIR : ST_CMP;
            end
            ST_CMP: begin
                if (eq) begin
                    state_next = ST_PAIR;
                end else if (keep) begin
                    have_next = 1'b1;
                    dmag_next = mag_d;
                    dpos_next = p_gt;
                    if (p_gt) begin
                        i_next = i_inc;
                    end else begin
                        j_next = j_inc;
                    end
                    if ((p_gt && i_inc == f_cnt_reg) || (!p_gt && j_inc == p_cnt_reg)) begin
                        // ran off one ring: keep its newest entry and the
                        // other ring from the current index, no pair
                        drop_f_next         = i_reg;
                        drop_p_next         = j_reg;
                        res_next            = '0;
                        res_next.overflowed = ovf_reg;
                        state_next          = ST_EMIT;
                    end else begin
                        state_next = ST_RD;
                    end
                end else begin
                    // difference did not shrink: step back the index that moved last
                    if (dpos_reg) begin
                        i_next = i_reg - ONE_C;
                    end else begin
                        j_next = j_reg - ONE_C;
                    end
                    fetch_next = 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_PAIR: begin
                res_next.paired          = 1'b1;
                res_next.frame_ms        = f_rd_reg.ms;
                res_next.frame_camera_ms = f_rd_reg.camera_ms;
                res_next.frame_handle    = f_rd_reg.handle;
                res_next.pose_ms         = p_rd_reg.ms;
                res_next.pose_handle     = p_rd_reg.handle;
                res_next.overflowed      = ovf_reg;
                drop_f_next              = i_inc;
                drop_p_next              = j_inc;
                state_next               = ST_EMIT;
            end
            ST_EMIT: begin
                if (!out_valid_reg || r_ready) begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    f_head_next    = wrap_idx(f_head_reg, drop_f_reg);
                    p_head_next    = wrap_idx(p_head_reg, drop_p_reg);
                    f_cnt_next     = f_cnt_reg - drop_f_reg;
                    p_cnt_next     = p_cnt_reg - drop_p_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            f_head_reg    <= '0;
            p_head_reg    <= '0;
            f_cnt_reg     <= '0;
            p_cnt_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            f_head_reg    <= f_head_next;
            p_head_reg    <= p_head_next;
            f_cnt_reg     <= f_cnt_next;
            p_cnt_reg     <= p_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        ovf_reg    <= ovf_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        have_reg   <= have_next;
        dmag_reg   <= dmag_next;
        dpos_reg   <= dpos_next;
        fetch_reg  <= fetch_next;
        drop_f_reg <= drop_f_next;
        drop_p_reg <= drop_p_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
    end

    // ring buffers: one write port at the tail, one registered read port
    always_ff @(posedge aclk) begin
        if (state_reg == ST_APPEND && item_reg.func == FUNC_FRAME) begin
            f_mem[f_wr_addr] <= '{ms: item_reg.stamp_ms, camera_ms: item_reg.camera_ms,
                                   handle: item_reg.handle};
        end
        f_rd_reg <= f_mem[f_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_APPEND && item_reg.func == FUNC_POSE) begin
            p_mem[p_wr_addr] <= '{ms: item_reg.stamp_ms, handle: item_reg.handle};
        end
        p_rd_reg <= p_mem[p_rd_addr];
    end

endmodule

FILE: src/nearest_timestamp_pairer_core.sv
// Flow: an accepted item passes ST_APPEND and ST_START, then a walk of S comparisons,
// each through ST_RD and ST_CMP (a refetch through ST_RD after a step back, ST_PAIR on a
// pair), then ST_EMIT into the result register; S <= 2*FIFO_DEPTH-1. With an empty ring
// ST_START goes straight to ST_EMIT. The matcher takes no new item until it has emitted
// the last one; the input queue holds up to two items meanwhile.
// Reset: aresetn, synchronous, active low; clears both rings, queue and output.
`timescale 1ns / 1ps

// Top level: input queue in front, matcher behind it, result register at
// the output. Uses ntp_pkg, ntp_in_queue and ntp_matcher.
module nearest_timestamp_pairer_core
    import ntp_pkg::*;
#(
    parameter int FIFO_DEPTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // stamp_ms[26:0], camera_ms[53:27], handle[69:54], zero pad [71:70]
    input  logic [S_DATA_W-1:0] s_tdata,
    // func[0]: 0 scan frame, 1 pose record
    input  logic [S_USER_W-1:0] s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // frame_ms[26:0], frame_camera_ms[53:27], frame_handle[69:54],
    // pose_ms[96:70], pose_handle[112:97], zero pad [119:113]
    output logic [M_DATA_W-1:0] m_tdata,
    // paired[0], overflowed[1]
    output logic [M_USER_W-1:0] m_tuser
);

    logic     q_valid, q_ready;
    in_item_t q_item;
    result_t  r_data;

    // front: hold up to two items while the matcher walks
    ntp_in_queue u_in_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    // back: append, walk, drop, register the result
    ntp_matcher #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_matcher (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item),
        .r_valid (m_tvalid),
        .r_ready (m_tready),
        .r_data  (r_data)
    );

    // pack the result fields, lowest field first
    assign m_tdata = {7'd0, r_data.pose_handle, r_data.pose_ms, r_data.frame_handle,
                      r_data.frame_camera_ms, r_data.frame_ms};
    assign m_tuser = {r_data.overflowed, r_data.paired};

endmodule

FILE: src/ntp_checker.sv
// ntp_checker: port-level checks on the timestamp pairer, bound to the top.
// Uses ntp_pkg; attaches to nearest_timestamp_pairer_core.
`timescale 1ns / 1ps

module ntp_checker
    import ntp_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic [M_USER_W-1:0] m_tuser
);

    // result register is cleared by reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // an unpaired result carries all-zero fields
    a_unpaired_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("unpaired result with nonzero fields");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while stalled");

endmodule

bind nearest_timestamp_pairer_core ntp_checker u_ntp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
